/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define MC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mcsef_pkg.sv */
// Shared types and constants of the moment checksum single error fix block.
// No dependencies; every other design file but assert_macros.svh refers to this package.
`timescale 1ns / 1ps

package mcsef_pkg;

	localparam int BLOCK_LEN_DEF = 512;
	localparam int RES_W         = 32;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = 10;

	typedef enum logic [1:0] {
		ST_CLEAN   = 2'd0,
		ST_FIXED   = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              last;
		logic [RES_W-1:0]  ref_sum0;
		logic [RES_W-1:0]  ref_sum1;
		logic [RES_W-1:0]  ref_sum2;
		logic [RES_W-1:0]  ref_sum3;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  error_position;
		logic [BYTE_W-1:0] error_delta;
	} out_t;

	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_TAKE  = 4'd1,
		OP_ACC1  = 4'd2,
		OP_ACC2  = 4'd3,
		OP_ACC3  = 4'd4,
		OP_ACC4  = 4'd5,
		OP_RES   = 4'd6,
		OP_DIVGO = 4'd7,
		OP_QLAT  = 4'd8,
		OP_PROD1 = 4'd9,
		OP_PROD2 = 4'd10,
		OP_PROD3 = 4'd11,
		OP_LOAD  = 4'd12
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic all_zero;
		logic d_ok;
		logic div_busy;
		logic q_ok;
		logic sq_ok;
		logic cube_ok;
	} stat_t;

endpackage

/* design/moment_checksum_single_error_fix.sv */
// Moment checksum single error fix. Bytes of a block stream in on the byte channel; the block
// keeps four power sums mod 2^32 (v, v*i, v*i^2, v*i^3 with 1-based position i). The byte
// marked last carries the four reference sums; its transfer yields exactly one result on the
// result channel: clean, a located single error (position and delta to subtract mod 256), or
// refused. Other bytes give no result. Bytes past BLOCK_LEN are counted out of the sums.
// Each byte transfer is followed by four steps (M1 to M4) that build the i, i^2, i^3 weights
// in the one shared 32 x CW multiplier and add them into the sums, the byte channel not ready
// meanwhile; once BLOCK_LEN bytes are in, further bytes skip those steps. A last byte then
// runs the residual check (residuals, evaluation, a wait on the 32-step bit-serial divider,
// quotient check, checks P1 to P4, result load; it ends early on a clean or refused outcome)
// before the byte channel is ready again, longer while an earlier result waits. A finished
// result sits in an output register, so the next block streams in while that result waits.
`timescale 1ns / 1ps

module moment_checksum_single_error_fix #(
	parameter int BLOCK_LEN = mcsef_pkg::BLOCK_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  mcsef_pkg::in_t  byte_data,
	output logic            result_valid,
	input  logic            result_ready,
	output mcsef_pkg::out_t result_data
);

	// command and status between the sequencer and the datapath
	mcsef_pkg::cmd_t  cmd;
	mcsef_pkg::stat_t stat;

	// hold the sequencer: it owns both handshakes and the result valid flag
	mcsef_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_last    (byte_data.last),
		.byte_ready   (byte_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// the datapath keeps the sums, residuals and the result payload register
	mcsef_dp #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.data_in (byte_data),
		.stat    (stat),
		.res     (result_data)
	);

endmodule

/* design/mcsef_div.sv */
// Restoring divider, one quotient bit per cycle, for residual / byte delta.
// Depends on mcsef_pkg for the operand widths.
`timescale 1ns / 1ps

module mcsef_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mcsef_pkg::RES_W-1:0]   dividend,
	input  logic [mcsef_pkg::BYTE_W-1:0]  divisor,
	output logic                          busy,
	output logic [mcsef_pkg::RES_W-1:0]   quo,
	output logic [mcsef_pkg::BYTE_W-1:0]  rem
);

	localparam int NW = mcsef_pkg::RES_W;
	localparam int DW = mcsef_pkg::BYTE_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, dvs_q});
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

/* design/mcsef_dp.sv */
// Datapath: byte counter, four power sums, residuals, shared multiplier and checks.
// Depends on mcsef_pkg and mcsef_div; driven by commands from mcsef_ctrl.
`timescale 1ns / 1ps

module mcsef_dp #(
	parameter int BLOCK_LEN = mcsef_pkg::BLOCK_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mcsef_pkg::cmd_t  cmd,
	input  mcsef_pkg::in_t   data_in,
	output mcsef_pkg::stat_t stat,
	output mcsef_pkg::out_t  res
);

	localparam int CW = $clog2(BLOCK_LEN + 1);
	localparam int RW = mcsef_pkg::RES_W;
	localparam int BW = mcsef_pkg::BYTE_W;
	localparam int PW = RW + CW;

	logic [CW-1:0] count_q;
	logic [RW-1:0] sum_q [4];
	logic [RW-1:0] ref_q [4];
	logic [RW-1:0] e_q   [4];
	logic [RW-1:0] prod_q;
	logic [CW-1:0] q_q;
	mcsef_pkg::out_t res_q;

	logic          full;
	logic          d_neg;
	logic [BW-1:0] abs_d;
	logic [RW-1:0] abs_n1;
	logic [RW-1:0] mul_a;
	logic [CW-1:0] mul_b;
	logic [PW-1:0] mul_p;
	logic          prod_sel;
	logic [RW:0]   sq_mag;
	logic [RW:0]   sq_val;
	logic [RW-1:0] cube_val;
	logic          div_busy;
	logic [RW-1:0] div_quo;
	logic [BW-1:0] div_rem;

	assign full  = count_q == CW'(BLOCK_LEN);
	assign d_neg = e_q[0][RW-1];
	assign abs_d = d_neg ? (~e_q[0][BW-1:0] + BW'(1)) : e_q[0][BW-1:0];
	assign abs_n1 = e_q[1][RW-1] ? (~e_q[1] + RW'(1)) : e_q[1];

	// one multiplier shared by the sum update and the candidate check
	assign prod_sel = (cmd.op == mcsef_pkg::OP_PROD1) || (cmd.op == mcsef_pkg::OP_PROD2)
		|| (cmd.op == mcsef_pkg::OP_PROD3);
	assign mul_a = (cmd.op == mcsef_pkg::OP_PROD1) ? RW'(abs_d) : prod_q;
	assign mul_b = prod_sel ? q_q : count_q;
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// d*q^2 is exact below 2^32 in magnitude; apply the sign of d
	assign sq_mag   = {1'b0, prod_q};
	assign sq_val   = d_neg ? (~sq_mag + (RW+1)'(1)) : sq_mag;
	assign cube_val = d_neg ? (~prod_q + RW'(1)) : prod_q;

	mcsef_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == mcsef_pkg::OP_DIVGO),
		.dividend (abs_n1),
		.divisor  (abs_d),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			sum_q[3] <= '0;
		end else begin
			case (cmd.op)
				mcsef_pkg::OP_TAKE: begin
					if (!full) begin
						count_q  <= count_q + CW'(1);
						sum_q[0] <= sum_q[0] + RW'(data_in.byte_value);
					end
				end
				mcsef_pkg::OP_ACC2: sum_q[1] <= sum_q[1] + prod_q;
				mcsef_pkg::OP_ACC3: sum_q[2] <= sum_q[2] + prod_q;
				mcsef_pkg::OP_ACC4: sum_q[3] <= sum_q[3] + prod_q;
				mcsef_pkg::OP_LOAD: begin
					count_q  <= '0;
					sum_q[0] <= '0;
					sum_q[1] <= '0;
					sum_q[2] <= '0;
					sum_q[3] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			mcsef_pkg::OP_TAKE: begin
				prod_q   <= RW'(data_in.byte_value);
				ref_q[0] <= data_in.ref_sum0;
				ref_q[1] <= data_in.ref_sum1;
				ref_q[2] <= data_in.ref_sum2;
				ref_q[3] <= data_in.ref_sum3;
			end
			mcsef_pkg::OP_ACC1, mcsef_pkg::OP_ACC2, mcsef_pkg::OP_ACC3,
			mcsef_pkg::OP_PROD1, mcsef_pkg::OP_PROD2, mcsef_pkg::OP_PROD3: begin
				prod_q <= mul_p[RW-1:0];
			end
			mcsef_pkg::OP_RES: begin
				e_q[0] <= sum_q[0] - ref_q[0];
				e_q[1] <= sum_q[1] - ref_q[1];
				e_q[2] <= sum_q[2] - ref_q[2];
				e_q[3] <= sum_q[3] - ref_q[3];
			end
			mcsef_pkg::OP_QLAT: q_q <= div_quo[CW-1:0];
			mcsef_pkg::OP_LOAD: begin
				res_q.status <= cmd.code;
				if (cmd.code == mcsef_pkg::ST_FIXED) begin
					res_q.error_position <= mcsef_pkg::POS_W'(q_q);
					res_q.error_delta    <= e_q[0][BW-1:0];
				end else begin
					res_q.error_position <= '0;
					res_q.error_delta    <= '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.full     = full;
		stat.all_zero = (e_q[0] | e_q[1] | e_q[2] | e_q[3]) == '0;
		stat.d_ok     = (e_q[0][BW-1:0] != '0)
			&& ((e_q[0][RW-1:BW] == '0) || (&e_q[0][RW-1:BW]));
		stat.div_busy = div_busy;
		stat.q_ok     = (div_rem == '0) && (e_q[1][RW-1] == d_neg) && (div_quo != '0)
			&& (div_quo <= RW'(count_q));
		stat.sq_ok    = sq_val == {e_q[2][RW-1], e_q[2]};
		stat.cube_ok  = cube_val == e_q[3];
	end

	assign res = res_q;

endmodule

/* design/mcsef_ctrl.sv */
// Controller: sequences byte accumulation, residual check and result transfer.
// Depends on mcsef_pkg; drives mcsef_dp through the command struct.
`timescale 1ns / 1ps

module mcsef_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic             byte_last,
	output logic             byte_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  mcsef_pkg::stat_t stat,
	output mcsef_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_M1   = 14'b00000000000010,
		S_M2   = 14'b00000000000100,
		S_M3   = 14'b00000000001000,
		S_M4   = 14'b00000000010000,
		S_RES  = 14'b00000000100000,
		S_EVAL = 14'b00000001000000,
		S_DIV  = 14'b00000010000000,
		S_QCHK = 14'b00000100000000,
		S_P1   = 14'b00001000000000,
		S_P2   = 14'b00010000000000,
		S_P3   = 14'b00100000000000,
		S_P4   = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

	state_t              state_q, state_d;
	mcsef_pkg::status_t  code_q, code_d;
	logic                last_q;
	logic                out_valid_q;
	logic                take;
	logic                out_free;

	assign byte_ready = state_q == S_IDLE;
	assign take       = byte_ready && byte_valid;
	assign out_free   = !out_valid_q || result_ready;

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = mcsef_pkg::OP_NONE;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.op = mcsef_pkg::OP_TAKE;
					if (!stat.full) begin
						state_d = S_M1;
					end else if (byte_last) begin
						state_d = S_RES;
					end
				end
			end
			S_M1: begin
				cmd.op  = mcsef_pkg::OP_ACC1;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.op  = mcsef_pkg::OP_ACC2;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.op  = mcsef_pkg::OP_ACC3;
				state_d = S_M4;
			end
			S_M4: begin
				cmd.op  = mcsef_pkg::OP_ACC4;
				state_d = last_q ? S_RES : S_IDLE;
			end
			S_RES: begin
				cmd.op  = mcsef_pkg::OP_RES;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.all_zero) begin
					code_d  = mcsef_pkg::ST_CLEAN;
					state_d = S_DONE;
				end else if (!stat.d_ok) begin
					code_d  = mcsef_pkg::ST_REFUSED;
					state_d = S_DONE;
				end else begin
					cmd.op  = mcsef_pkg::OP_DIVGO;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_QCHK;
				end
			end
			S_QCHK: begin
				cmd.op = mcsef_pkg::OP_QLAT;
				if (stat.q_ok) begin
					state_d = S_P1;
				end else begin
					code_d  = mcsef_pkg::ST_REFUSED;
					state_d = S_DONE;
				end
			end
			S_P1: begin
				cmd.op  = mcsef_pkg::OP_PROD1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.op  = mcsef_pkg::OP_PROD2;
				state_d = S_P3;
			end
			S_P3: begin
				cmd.op = mcsef_pkg::OP_PROD3;
				if (stat.sq_ok) begin
					state_d = S_P4;
				end else begin
					code_d  = mcsef_pkg::ST_REFUSED;
					state_d = S_DONE;
				end
			end
			S_P4: begin
				code_d  = stat.cube_ok ? mcsef_pkg::ST_FIXED : mcsef_pkg::ST_REFUSED;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.op  = mcsef_pkg::OP_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= mcsef_pkg::ST_CLEAN;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (take) begin
				last_q <= byte_last;
			end
			if (cmd.op == mcsef_pkg::OP_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

/* design/mcsef_checker.sv */
// Port-level checker for the moment checksum single error fix block, bound to the top level.
// Depends on mcsef_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcsef_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            byte_valid,
	input logic            byte_ready,
	input mcsef_pkg::in_t  byte_data,
	input logic            result_valid,
	input logic            result_ready,
	input mcsef_pkg::out_t result_data
);

	`MC_ASSERT_IMPL(a_status_code, result_valid, (result_data.status == mcsef_pkg::ST_CLEAN) || (result_data.status == mcsef_pkg::ST_FIXED) || (result_data.status == mcsef_pkg::ST_REFUSED), "result status outside its codes")
	`MC_ASSERT_IMPL(a_zero_unless_fixed, result_valid && (result_data.status != mcsef_pkg::ST_FIXED), (result_data.error_position == '0) && (result_data.error_delta == '0), "position or delta set without a fix")
	`MC_ASSERT_IMPL(a_fix_delta, result_valid && (result_data.status == mcsef_pkg::ST_FIXED), result_data.error_delta != '0, "fix with a zero delta")
	`MC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result dropped or changed")
	`MC_ASSERT_NEXT(a_last_closes_input, byte_valid && byte_ready && byte_data.last, !byte_ready, "byte channel open after last")

endmodule

bind moment_checksum_single_error_fix mcsef_checker u_mcsef_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.byte_data    (byte_data),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);
